@@ rtl/core/lfse_pkg.sv @@
// Shared constants and types for the LED frame SPI encoder.
package lfse_pkg;

  localparam int unsigned LED_COUNT    = 39;
  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned LED_IDX_W    = $clog2(LED_COUNT);
  localparam int unsigned BIT_IDX_W    = $clog2(BITS_PER_LED);
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Logical to physical remap: two spans of ten LEDs trade places.
  localparam logic [7:0] SWAP_LOW_START  = 8'd9;
  localparam logic [7:0] SWAP_LOW_END    = 8'd18;
  localparam logic [7:0] SWAP_HIGH_START = 8'd29;
  localparam logic [7:0] SWAP_HIGH_END   = 8'd38;
  localparam logic [7:0] SWAP_OFFSET     = 8'd20;

  localparam logic [7:0] ONE_PATTERN_RST  = 8'hfc;
  localparam logic [7:0] ZERO_PATTERN_RST = 8'h80;

  // Configuration register indexes.
  localparam logic [7:0] REG_ONE_PATTERN  = 8'd0;
  localparam logic [7:0] REG_ZERO_PATTERN = 8'd1;

  // Host function codes.
  localparam logic [1:0] FUNC_SET_ALL = 2'd0;
  localparam logic [1:0] FUNC_SET_ONE = 2'd1;
  localparam logic [1:0] FUNC_PULL    = 2'd2;

  typedef enum logic [1:0] {
    CMD_SET_ALL = 2'd0,
    CMD_SET_ONE = 2'd1,
    CMD_PULL    = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                  kind;
    logic [LED_IDX_W-1:0]  phys;
    logic [BITS_PER_LED-1:0] colour;
  } cmd_t;

endpackage

@@ rtl/core/lfse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lfse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/lfse_front.sv @@
// Command front end: accepts host items, remaps/filters them, queues commands.
module lfse_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          func_i,
  input  logic [7:0]          led_index_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                cmd_valid_o,
  output lfse_pkg::cmd_t      cmd_o
);

  localparam int unsigned PtrW = $clog2(lfse_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(lfse_pkg::QUEUE_DEPTH + 1);

  lfse_pkg::cmd_t   entry_q [lfse_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  lfse_pkg::cmd_t   cmd_new;
  logic             keep;
  logic             push;
  logic             pop;
  logic [7:0]       phys_wide;

  // Classify: drop unused func codes and unmapped indexes.
  always_comb begin
    phys_wide      = led_index_i;
    if (led_index_i inside {[lfse_pkg::SWAP_LOW_START:lfse_pkg::SWAP_LOW_END]}) begin
      phys_wide = led_index_i + lfse_pkg::SWAP_OFFSET;
    end else if (led_index_i inside
                 {[lfse_pkg::SWAP_HIGH_START:lfse_pkg::SWAP_HIGH_END]}) begin
      phys_wide = led_index_i - lfse_pkg::SWAP_OFFSET;
    end
    cmd_new.phys   = phys_wide[lfse_pkg::LED_IDX_W-1:0];
    cmd_new.colour = {green_i, red_i, blue_i};
    cmd_new.kind   = lfse_pkg::CMD_PULL;
    keep           = 1'b0;
    case (func_i)
      lfse_pkg::FUNC_SET_ALL: begin
        cmd_new.kind = lfse_pkg::CMD_SET_ALL;
        keep         = 1'b1;
      end
      lfse_pkg::FUNC_SET_ONE: begin
        cmd_new.kind = lfse_pkg::CMD_SET_ONE;
        keep         = ({1'b0, led_index_i} < 9'(lfse_pkg::LED_COUNT));
      end
      lfse_pkg::FUNC_PULL: begin
        cmd_new.kind = lfse_pkg::CMD_PULL;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy_o      = (count_q == CntW'(lfse_pkg::QUEUE_DEPTH));
  assign push        = start_i && !busy_o && keep;
  assign pop         = (count_q != '0);
  assign cmd_valid_o = pop;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(lfse_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(lfse_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(lfse_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");
  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");
  a_valid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !cmd_valid_o)
    else $error("command offered from empty queue");
`endif

endmodule

@@ rtl/core/lfse_back.sv @@
// Command back end: colour store, frame position and SPI byte encoding.
module lfse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  lfse_pkg::cmd_t      cmd_i,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output logic                out_strobe_o,
  output logic [7:0]          spi_byte_o,
  output logic                frame_last_o
);

  localparam int unsigned LedW = lfse_pkg::LED_IDX_W;
  localparam int unsigned BitW = lfse_pkg::BIT_IDX_W;
  localparam int unsigned ColW = lfse_pkg::BITS_PER_LED;

  logic [lfse_pkg::LED_COUNT-1:0] valid_q;
  logic [ColW-1:0]  global_q;
  logic [LedW-1:0]  led_q;
  logic [BitW-1:0]  bit_q;
  logic [7:0]       one_pat_q, zero_pat_q;

  // read stage
  logic             s2_valid_q;
  logic             s2_own_q;
  logic [ColW-1:0]  s2_global_q;
  logic [BitW-1:0]  s2_bit_q;
  logic             s2_last_q;

  logic             do_set_all, do_set_one, do_pull;
  logic             last_byte;
  logic [ColW-1:0]  ram_rdata;
  logic [ColW-1:0]  colour;

  always_comb begin
    do_set_all = 1'b0;
    do_set_one = 1'b0;
    do_pull    = 1'b0;
    if (cmd_valid_i) begin
      case (cmd_i.kind)
        lfse_pkg::CMD_SET_ALL: do_set_all = 1'b1;
        lfse_pkg::CMD_SET_ONE: do_set_one = 1'b1;
        lfse_pkg::CMD_PULL:    do_pull    = 1'b1;
        default: begin
          do_pull = 1'b0;
        end
      endcase
    end
  end

  assign last_byte = (led_q == LedW'(lfse_pkg::LED_COUNT - 1)) && (bit_q == '0);

  lfse_ram #(
    .Width (ColW),
    .Depth (lfse_pkg::LED_COUNT)
  ) u_colour_ram (
    .clk_i   (clk_i),
    .we_i    (do_set_one),
    .waddr_i (cmd_i.phys),
    .wdata_i (cmd_i.colour),
    .re_i    (do_pull),
    .raddr_i (led_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      global_q   <= '0;
      led_q      <= '0;
      bit_q      <= BitW'(ColW - 1);
      one_pat_q  <= lfse_pkg::ONE_PATTERN_RST;
      zero_pat_q <= lfse_pkg::ZERO_PATTERN_RST;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= do_pull;
      if (do_set_all) begin
        global_q <= cmd_i.colour;
        valid_q  <= '0;
      end
      if (do_set_one) begin
        valid_q[cmd_i.phys] <= 1'b1;
      end
      if (do_pull) begin
        if (bit_q == '0) begin
          bit_q <= BitW'(ColW - 1);
          led_q <= last_byte ? '0 : led_q + 1'b1;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      end
      if (cfg_valid_i && cfg_index_i == lfse_pkg::REG_ONE_PATTERN) begin
        one_pat_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == lfse_pkg::REG_ZERO_PATTERN) begin
        zero_pat_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pull) begin
      s2_own_q    <= valid_q[led_q];
      s2_global_q <= global_q;
      s2_bit_q    <= bit_q;
      s2_last_q   <= last_byte;
    end
  end

  // LED not written since the last set-all shows the set-all colour
  assign colour       = s2_own_q ? ram_rdata : s2_global_q;
  assign out_strobe_o = s2_valid_q;
  assign spi_byte_o   = colour[s2_bit_q] ? one_pat_q : zero_pat_q;
  assign frame_last_o = s2_valid_q && s2_last_q;

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (led_q < LedW'(lfse_pkg::LED_COUNT)) && (bit_q < BitW'(ColW)))
    else $error("frame position out of range");
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pull && last_byte) |=> (led_q == '0 && bit_q == BitW'(ColW - 1)))
    else $error("frame did not wrap after last byte");
  a_strobe_follows_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(do_pull))
    else $error("result without pull");
  a_set_all_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_set_all |=> (valid_q == '0))
    else $error("set-all left stale per-LED colours");
`endif

endmodule

@@ rtl/core/led_frame_spi_encoder.sv @@
// Top level of the LED frame SPI encoder.
//
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. func_i picks set-all (colour to every LED), set-one
//   (led_index_i remapped to a physical LED; 39 and above dropped) or pull
//   (emit the next SPI byte of the frame). Unused func code is dropped.
//   Result: a pull yields one byte on spi_byte_o with frame_last_o, shown for
//   exactly one cycle while out_strobe_o is high; the receiver cannot stall.
//   A pull passes the command queue, then the read stage. Throughput: one item
//   per cycle unless busy; the command queue drains one command per cycle
//   into the back end, whose colour RAM has one write and one read port.
//   Set commands give no result; a frame half sent goes on with new colours.
//   Frame: LEDs in physical order, green, red, blue, MSB first, 936 bytes.
//   Config: cfg_valid_i/cfg_ready_o write one_pattern (index 0) or
//   zero_pattern (index 1); other indexes ignored. Write only while idle.
//   Reset: all colours zero, frame position zero, patterns 0xfc / 0x80.
//   No clearing pass; per-LED valid bits stand in for the RAM reset.
module led_frame_spi_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func_i,
  input  logic [7:0] led_index_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_strobe_o,
  output logic [7:0] spi_byte_o,
  output logic       frame_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic           cmd_valid;
  lfse_pkg::cmd_t cmd;

  // Registers are plain flops, always writable.
  assign cfg_ready_o = 1'b1;

  lfse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .func_i      (func_i),
    .led_index_i (led_index_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  lfse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_strobe_o (out_strobe_o),
    .spi_byte_o   (spi_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ sim/led_frame_spi_encoder_test.sv @@
// Self-checking test of the LED frame SPI encoder: strip colours, remap, frame bytes.

// Tracks the strip colours and the frame position, and holds the SPI bytes still owed.
class spi_frame_tracker;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last;
  } spi_out_t;

  localparam int unsigned FRAME_BYTES = lfse_pkg::LED_COUNT * lfse_pkg::BITS_PER_LED;

  logic [23:0]  strip [lfse_pkg::LED_COUNT];
  logic [9:0]   frame_pos;
  logic [7:0]   one_pat;
  logic [7:0]   zero_pat;
  spi_out_t     pending [$];
  int unsigned  errors;
  int unsigned  bytes_checked;
  int unsigned  frames_done;

  function new();
    foreach (strip[i]) strip[i] = '0;
    frame_pos     = '0;
    one_pat       = lfse_pkg::ONE_PATTERN_RST;
    zero_pat      = lfse_pkg::ZERO_PATTERN_RST;
    errors        = 0;
    bytes_checked = 0;
    frames_done   = 0;
  endfunction

  // Logical 9..18 and 29..38 trade places.
  function logic [7:0] to_physical(logic [7:0] logical);
    if (logical >= lfse_pkg::SWAP_LOW_START && logical <= lfse_pkg::SWAP_LOW_END)
      return logical + lfse_pkg::SWAP_OFFSET;
    if (logical >= lfse_pkg::SWAP_HIGH_START && logical <= lfse_pkg::SWAP_HIGH_END)
      return logical - lfse_pkg::SWAP_OFFSET;
    return logical;
  endfunction

  function void write_register(logic [7:0] index, logic [7:0] data);
    case (index)
      lfse_pkg::REG_ONE_PATTERN:  one_pat = data;
      lfse_pkg::REG_ZERO_PATTERN: zero_pat = data;
      default: ;
    endcase
  endfunction

  function void note_command(logic [1:0] func, logic [7:0] index,
                             logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    logic [23:0] colour;
    int unsigned pos;
    spi_out_t    res;
    colour = {green, red, blue};
    case (func)
      lfse_pkg::FUNC_SET_ALL: begin
        foreach (strip[i]) strip[i] = colour;
      end
      lfse_pkg::FUNC_SET_ONE: begin
        if (index < lfse_pkg::LED_COUNT) strip[to_physical(index)] = colour;
      end
      lfse_pkg::FUNC_PULL: begin
        pos = frame_pos;
        if (pos >= FRAME_BYTES) pos = 0;
        res.spi_byte = strip[pos / lfse_pkg::BITS_PER_LED]
                            [lfse_pkg::BITS_PER_LED - 1 - pos % lfse_pkg::BITS_PER_LED]
                       ? one_pat : zero_pat;
        res.last = (pos == FRAME_BYTES - 1);
        pending.push_back(res);
        frame_pos = res.last ? 10'd0 : 10'(pos + 1);
      end
      default: ;
    endcase
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task check_result(logic [7:0] spi_byte, logic last);
    spi_out_t want;
    if (pending.size() == 0) begin
      report($sformatf("byte %02h arrived with nothing owed", spi_byte));
      return;
    end
    want = pending.pop_front();
    bytes_checked++;
    if (spi_byte !== want.spi_byte)
      report($sformatf("spi_byte %02h, want %02h", spi_byte, want.spi_byte));
    if (last !== want.last)
      report($sformatf("frame_last %b, want %b", last, want.last));
    if (want.last) frames_done++;
  endtask

endclass

module led_frame_spi_encoder_test;

  localparam int unsigned CMDS_PER_PHASE = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // A strobe passes the command queue and the read stage; a set has no strobe, so wait it out.
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
  localparam logic [7:0]  REG_UNMAPPED   = 8'd2;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  logic [1:0] func_i      = '0;
  logic [7:0] led_index_i = '0;
  logic [7:0] red_i       = '0;
  logic [7:0] green_i     = '0;
  logic [7:0] blue_i      = '0;
  logic       out_strobe_o;
  logic [7:0] spi_byte_o;
  logic       frame_last_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i  = '0;

  spi_frame_tracker tracker;
  int unsigned      stall_cycles = 0;
  int unsigned      cmds_taken   = 0;
  int unsigned      reg_writes   = 0;

  led_frame_spi_encoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .led_index_i  (led_index_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_strobe_o (out_strobe_o),
    .spi_byte_o   (spi_byte_o),
    .frame_last_o (frame_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Monitor: everything is sampled at the rising edge, before the block updates.
  // Results are checked before the new command is noted: a strobe at this edge
  // always belongs to a command taken at an earlier edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_strobe_o) tracker.check_result(spi_byte_o, frame_last_o);
      if (start && !busy) begin
        tracker.note_command(func_i, led_index_i, red_i, green_i, blue_i);
        cmds_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        tracker.write_register(cfg_index_i, cfg_data_i);
        reg_writes++;
      end
      // Watchdog: any handshake or strobe counts as progress.
      if (out_strobe_o || (start && !busy) || (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Present one command at the falling edge and hold it until busy is low at a
  // rising edge. start stays high; the next call or a pause decides its fate.
  task automatic send_cmd(input logic [1:0] func, input logic [7:0] index,
                          input logic [7:0] red, input logic [7:0] green,
                          input logic [7:0] blue);
    @(negedge clk_i);
    start       <= 1'b1;
    func_i      <= func;
    led_index_i <= index;
    red_i       <= red;
    green_i     <= green;
    blue_i      <= blue;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Hold off the sender until every owed byte is out and any set has drained.
  task automatic settle();
    pause(1);
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Colour levels lean on the extremes.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly mapped LEDs, with weight on the edges of the swapped spans.
  function automatic logic [7:0] pick_led();
    logic [7:0] edges [8];
    edges = '{8'd0, 8'd8, 8'd9, 8'd18, 8'd19, 8'd28, 8'd29, 8'd38};
    case ($urandom_range(9))
      6, 7: return edges[$urandom_range(7)];
      8: return 8'($urandom_range(255, lfse_pkg::LED_COUNT));
      9: return 8'($urandom_range(255));
      default: return 8'($urandom_range(lfse_pkg::LED_COUNT - 1));
    endcase
  endfunction

  // Pull-heavy mix so the frame position sweeps through the end of the frame.
  // Dropped commands (unused code, unmapped index) do not count toward the total.
  task automatic random_cmds(input int unsigned count, input int unsigned idle_pct);
    int unsigned done;
    int unsigned roll;
    logic [7:0]  index;
    done = 0;
    while (done < count) begin
      while ($urandom_range(99) < idle_pct) pause(1);
      roll = $urandom_range(99);
      if (roll < 82) begin
        send_cmd(lfse_pkg::FUNC_PULL, 8'($urandom_range(255)), pick_level(),
                 pick_level(), pick_level());
        done++;
      end else if (roll < 94) begin
        index = pick_led();
        send_cmd(lfse_pkg::FUNC_SET_ONE, index, pick_level(), pick_level(),
                 pick_level());
        if (index < lfse_pkg::LED_COUNT) done++;
      end else if (roll < 98) begin
        send_cmd(lfse_pkg::FUNC_SET_ALL, 8'($urandom_range(255)), pick_level(),
                 pick_level(), pick_level());
        done++;
      end else begin
        send_cmd(FUNC_UNUSED, 8'($urandom_range(255)), pick_level(), pick_level(),
                 pick_level());
      end
    end
  endtask

  // Pattern settings per phase: extremes in two, random in the others, plus
  // writes to indexes the block must ignore.
  task automatic program_patterns(input int unsigned phase);
    case (phase)
      0: begin
        write_reg(lfse_pkg::REG_ONE_PATTERN, 8'hff);
        write_reg(lfse_pkg::REG_ZERO_PATTERN, 8'h00);
        write_reg(REG_UNMAPPED, 8'h5a);
      end
      2: begin
        write_reg(lfse_pkg::REG_ONE_PATTERN, 8'h00);
        write_reg(lfse_pkg::REG_ZERO_PATTERN, 8'hff);
        write_reg(8'hff, 8'($urandom_range(255)));
      end
      default: begin
        write_reg(lfse_pkg::REG_ONE_PATTERN, 8'($urandom_range(255)));
        write_reg(lfse_pkg::REG_ZERO_PATTERN, 8'($urandom_range(255)));
      end
    endcase
  endtask

  initial begin
    // Sender idle percentage per phase: none, heavy, none, light.
    int unsigned idle_pct [4];
    idle_pct = '{0, 83, 0, 13};
    tracker  = new();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset patterns and colours first, then remap edges and drops.
    send_cmd(lfse_pkg::FUNC_PULL, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(lfse_pkg::FUNC_SET_ALL, 8'hff, 8'hff, 8'hff, 8'hff);
    send_cmd(lfse_pkg::FUNC_PULL, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(lfse_pkg::FUNC_PULL, 8'hff, 8'hff, 8'hff, 8'hff);
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'd9, 8'h12, 8'h34, 8'h56);
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'd18, 8'h9a, 8'hbc, 8'hde);
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'd29, 8'h01, 8'h02, 8'h03);
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'd38, 8'hf0, 8'h0f, 8'ha5);
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'd8, 8'h80, 8'h40, 8'h20);
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'd19, 8'h11, 8'h22, 8'h33);
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'd28, 8'h44, 8'h55, 8'h66);
    // Index without mapping and the unused code: no change, no byte.
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'd39, 8'h00, 8'h00, 8'h00);
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'hff, 8'h00, 8'h00, 8'h00);
    send_cmd(FUNC_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
    // Recolour LED 0 mid-frame; the remaining green bits follow the new value.
    send_cmd(lfse_pkg::FUNC_SET_ONE, 8'd0, 8'hff, 8'h0f, 8'h00);
    repeat (4) send_cmd(lfse_pkg::FUNC_PULL, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(lfse_pkg::FUNC_SET_ALL, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (2) send_cmd(lfse_pkg::FUNC_PULL, 8'h00, 8'h00, 8'h00, 8'h00);

    // Random phases; the sender drains fully before each register update.
    for (int unsigned phase = 0; phase < 4; phase++) begin
      settle();
      program_patterns(phase);
      random_cmds(CMDS_PER_PHASE, idle_pct[phase]);
    end

    // Drain and let the pipeline run empty.
    pause(1);
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (tracker.pending.size() != 0)
      tracker.report($sformatf("%0d bytes never arrived", tracker.pending.size()));
    $display("run: %0d commands taken, %0d SPI bytes checked, %0d full frames",
             cmds_taken, tracker.bytes_checked, tracker.frames_done);
    $display("run: %0d register writes over four idle/busy phases, %0d mismatches",
             reg_writes, tracker.errors);
    if (tracker.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
